### src/gle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the GIF LZW encoder.
// No dependencies.
package gle_pkg;

	localparam int KEY_W  = 20;   // {prefix, pixel}
	localparam int CODE_W = 12;
	localparam int EP_W   = 8;    // dictionary generation tag

	localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
	localparam logic [CODE_W-1:0] CODE_END   = 12'd257;
	localparam logic [12:0]       FIRST_FREE = 13'd258;
	localparam logic [12:0]       CODE_LIMIT = 13'd4096;
	localparam logic [3:0]        MIN_WIDTH  = 4'd9;
	localparam logic [3:0]        MAX_WIDTH  = 4'd12;

	typedef struct packed {
		logic [EP_W-1:0]   ep;
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] code;
	} dict_entry_t;

endpackage

### src/gif_lzw_encoder.sv
`timescale 1ns / 1ps
// GIF LZW encoder: hashed dictionary in one synchronous memory, LSB-first bit packer.
// Depends on gle_pkg.

// Takes one 8-bit palette index per transfer and returns the packed LSB-first
// LZW code stream, one byte per transfer, last_byte set on the final (padded)
// byte of each image. A pixel that opens an image sends a clear code (S_FIRST);
// any other pixel is hashed (S_H1, S_H2) and read from the dictionary (S_RD,
// S_CMP), takes one more read and compare per extra hash probe, one state for a
// miss (S_MISS) and one more (S_CLR) when that miss fills the dictionary and
// sends a clear code; the last pixel of an image then sends the final prefix
// and the end code (S_LAST_P, S_LAST_E). A code also waits while the packer
// still holds a full byte, and the clear code of the next image waits until
// the last byte of the previous one has left the packer; the dictionary
// memory's single read port makes each probe a separate read and compare. Valid
// marks are generation tags: after reset, and once every 255 dictionary resets,
// a clearing pass sweeps all HASH_SLOTS slots, during which no pixel is accepted.
module gif_lzw_encoder #(
	parameter int HASH_SLOTS = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel,
	input  logic       last_pixel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] code_byte,
	output logic       last_byte
);

	localparam int IDX_W = $clog2(HASH_SLOTS);
	localparam int SH    = gle_pkg::KEY_W + IDX_W;
	localparam int M_W   = gle_pkg::KEY_W + 2;
	localparam longint RECIP = ((64'd1 << SH) + HASH_SLOTS - 1) / HASH_SLOTS;
	localparam int P_W   = gle_pkg::KEY_W + M_W;
	localparam int Q_W   = gle_pkg::KEY_W + 1 - IDX_W;
	localparam logic [M_W-1:0]   RECIP_C = M_W'(RECIP);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_SLOTS - 1);
	localparam logic [gle_pkg::KEY_W:0] SLOTS_C = (gle_pkg::KEY_W + 1)'(HASH_SLOTS);

	localparam logic [3:0] S_SWEEP  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_FIRST  = 4'd2;
	localparam logic [3:0] S_H1     = 4'd3;
	localparam logic [3:0] S_H2     = 4'd4;
	localparam logic [3:0] S_RD     = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_MISS   = 4'd7;
	localparam logic [3:0] S_CLR    = 4'd8;
	localparam logic [3:0] S_LAST_P = 4'd9;
	localparam logic [3:0] S_LAST_E = 4'd10;

	logic [3:0] state_q;
	logic [7:0] px_q;
	logic       last_q;
	logic       in_image_q;
	logic [gle_pkg::CODE_W-1:0] prefix_q;
	logic [12:0] nfc_q;
	logic [3:0]  cw_q;
	logic [gle_pkg::EP_W-1:0] ep_q;
	logic [IDX_W-1:0] idx_q;
	logic [P_W-1:0]   prod_q;
	gle_pkg::dict_entry_t rd_q;
	gle_pkg::dict_entry_t mem [HASH_SLOTS];

	logic [19:0] acc_q;
	logic [4:0]  cnt_q;
	logic        fin_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        lastb_q;

	logic [gle_pkg::KEY_W-1:0] key;
	logic [Q_W-1:0] quot;
	logic [gle_pkg::KEY_W:0] rem_w;
	logic emit_v;
	logic [gle_pkg::CODE_W-1:0] emit_code;
	logic emit_fin;
	logic pk_ready;
	logic emit_ok;
	logic [gle_pkg::CODE_W-1:0] mask;
	logic [gle_pkg::CODE_W-1:0] code_m;
	logic [12:0] nfc_nx;
	logic hit;
	logic we;
	logic [IDX_W-1:0] waddr;
	gle_pkg::dict_entry_t wdata;
	logic drain;
	logic ep_wrap;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign code_byte = byte_q;
	assign last_byte = lastb_q;

	assign key    = {prefix_q, px_q};
	assign quot   = prod_q[SH +: Q_W];
	assign rem_w  = {1'b0, key} - (gle_pkg::KEY_W + 1)'(quot * SLOTS_C);
	assign nfc_nx = nfc_q + 13'd1;
	assign hit    = (rd_q.ep == ep_q) && (rd_q.key == key);
	assign ep_wrap = (ep_q == {gle_pkg::EP_W{1'b1}});

	always_comb begin
		emit_v    = 1'b0;
		emit_code = gle_pkg::CODE_CLEAR;
		emit_fin  = 1'b0;
		unique case (state_q)
			S_FIRST, S_CLR: begin
				emit_v = 1'b1;
			end
			S_MISS, S_LAST_P: begin
				emit_v    = 1'b1;
				emit_code = prefix_q;
			end
			S_LAST_E: begin
				emit_v    = 1'b1;
				emit_code = gle_pkg::CODE_END;
				emit_fin  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign pk_ready = (cnt_q < 5'd8) && !fin_q;
	assign emit_ok  = emit_v && pk_ready;
	assign mask     = gle_pkg::CODE_W'((13'd1 << cw_q) - 13'd1);
	assign code_m   = emit_code & mask;
	assign drain    = (!ov_q || out_ready) &&
	                  ((cnt_q >= 5'd8) || (fin_q && (cnt_q != 5'd0)));

	// single write port: sweep, or insert on a miss
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '{ep: ep_q, key: key, code: nfc_q[gle_pkg::CODE_W-1:0]};
		if (state_q == S_SWEEP) begin
			we    = 1'b1;
			wdata = '{ep: '0, key: '0, code: '0};
		end else if ((state_q == S_CMP) && (rd_q.ep != ep_q)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		prod_q <= P_W'(key) * P_W'(RECIP_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			px_q       <= '0;
			last_q     <= 1'b0;
			in_image_q <= 1'b0;
			prefix_q   <= '0;
			nfc_q      <= gle_pkg::FIRST_FREE;
			cw_q       <= gle_pkg::MIN_WIDTH;
			ep_q       <= '0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_IDX) begin
						ep_q    <= gle_pkg::EP_W'(1);
						state_q <= last_q ? S_LAST_P : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						px_q    <= pixel;
						last_q  <= last_pixel;
						state_q <= in_image_q ? S_H1 : S_FIRST;
					end
				end
				S_FIRST: begin
					if (emit_ok) begin
						prefix_q   <= {4'd0, px_q};
						in_image_q <= 1'b1;
						state_q    <= last_q ? S_LAST_P : S_IDLE;
					end
				end
				S_H1: begin
					state_q <= S_H2;
				end
				S_H2: begin
					idx_q   <= rem_w[IDX_W-1:0];
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					priority if (rd_q.ep != ep_q) begin
						state_q <= S_MISS;
					end else if (hit) begin
						prefix_q <= rd_q.code;
						state_q  <= last_q ? S_LAST_P : S_IDLE;
					end else begin
						// probe the next slot
						idx_q   <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_MISS: begin
					if (emit_ok) begin
						nfc_q    <= nfc_nx;
						prefix_q <= {4'd0, px_q};
						if ((nfc_nx == (13'd1 << cw_q) + 13'd1) && (cw_q < gle_pkg::MAX_WIDTH)) begin
							cw_q <= cw_q + 4'd1;
						end
						if (nfc_nx >= gle_pkg::CODE_LIMIT) begin
							state_q <= S_CLR;
						end else begin
							state_q <= last_q ? S_LAST_P : S_IDLE;
						end
					end
				end
				S_CLR: begin
					if (emit_ok) begin
						nfc_q <= gle_pkg::FIRST_FREE;
						cw_q  <= gle_pkg::MIN_WIDTH;
						if (ep_wrap) begin
							idx_q   <= '0;
							state_q <= S_SWEEP;
						end else begin
							ep_q    <= ep_q + gle_pkg::EP_W'(1);
							state_q <= last_q ? S_LAST_P : S_IDLE;
						end
					end
				end
				S_LAST_P: begin
					if (emit_ok) begin
						state_q <= S_LAST_E;
					end
				end
				S_LAST_E: begin
					if (emit_ok) begin
						in_image_q <= 1'b0;
						prefix_q   <= '0;
						last_q     <= 1'b0;
						nfc_q      <= gle_pkg::FIRST_FREE;
						cw_q       <= gle_pkg::MIN_WIDTH;
						if (ep_wrap) begin
							idx_q   <= '0;
							state_q <= S_SWEEP;
						end else begin
							ep_q    <= ep_q + gle_pkg::EP_W'(1);
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// bit packer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			ov_q    <= 1'b0;
			byte_q  <= '0;
			lastb_q <= 1'b0;
		end else begin
			if (drain) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (emit_ok) begin
				acc_q <= acc_q | (20'(code_m) << cnt_q[2:0]);
				cnt_q <= cnt_q + {1'b0, cw_q};
				fin_q <= emit_fin;
			end else if (drain) begin
				byte_q  <= acc_q[7:0];
				lastb_q <= fin_q && (cnt_q <= 5'd8);
				acc_q   <= acc_q >> 8;
				if (cnt_q >= 5'd8) begin
					cnt_q <= cnt_q - 5'd8;
				end else begin
					cnt_q <= '0;
				end
				if (cnt_q <= 5'd8) begin
					fin_q <= 1'b0;
				end
			end
		end
	end

endmodule

### src/gle_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the GIF LZW encoder, bound to the top level.
// Depends on gif_lzw_encoder.
module gle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] code_byte,
	input logic       last_byte
);

	// one pixel at a time: ready drops after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a pixel is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_byte) && $stable(last_byte))
		else $error("stalled output byte changed");

	// an image end can not be followed by another image end right away
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !(out_valid && last_byte))
		else $error("two image ends back to back");

endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.code_byte (code_byte),
	.last_byte (last_byte)
);

### dv/tb_gif_lzw_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench of the GIF LZW encoder: a table of directed pixels, then random images.
// Depends on gle_pkg and gif_lzw_encoder; expected bytes: behavioral LZW packer or typed table.
module tb_gif_lzw_encoder;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int HOLD_CYCLES    = 400;

	typedef struct {
		logic [7:0] pixel;
		logic       last;
		bit         typed;
		logic [7:0] bytes [4];
	} stim_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] pixel;
	logic       last_pixel;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] code_byte;
	logic       last_byte;

	gif_lzw_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel(pixel), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.code_byte(code_byte), .last_byte(last_byte)
	);

	stim_t     stim [$];
	out_byte_t expected_bytes [$];
	out_byte_t step_bytes [$];
	int        send_idx;
	int        accept_idx;
	int        errors;
	int        idle_cycles;
	bit        hold_done;

	// encoder state as seen from outside
	bit          enc_in_image;
	logic [11:0] enc_prefix;
	int unsigned enc_next_code;
	int unsigned enc_width;
	int unsigned enc_acc;
	int unsigned enc_count;
	logic [11:0] enc_dict [int unsigned];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at item %0d: %s", accept_idx, msg);
		errors++;
	endtask

	function automatic void dict_clear();
		enc_dict.delete();
		enc_next_code = 32'(gle_pkg::FIRST_FREE);
		enc_width = 32'(gle_pkg::MIN_WIDTH);
	endfunction

	function automatic void pack_code(input int unsigned code);
		out_byte_t b;
		code &= (1 << enc_width) - 1;
		enc_acc = (enc_acc | (code << (enc_count & 7))) & 32'hFFFFF;
		enc_count = (enc_count & 7) + enc_width;
		while (enc_count >= 8) begin
			b.data = enc_acc[7:0];
			b.last = 1'b0;
			step_bytes = {step_bytes, b};
			enc_acc >>= 8;
			enc_count -= 8;
		end
	endfunction

	function automatic void lzw_encode_pixel(input logic [7:0] px, input logic last);
		int unsigned key;
		out_byte_t   b;
		step_bytes.delete();
		if (!enc_in_image) begin
			pack_code(32'(gle_pkg::CODE_CLEAR));
			enc_prefix = {4'd0, px};
			enc_in_image = 1'b1;
		end else begin
			key = 32'({enc_prefix, px});
			if (enc_dict.exists(key)) begin
				enc_prefix = enc_dict[key];
			end else begin
				pack_code(32'(enc_prefix));
				enc_dict[key] = enc_next_code[11:0];
				enc_next_code++;
				if (enc_next_code == (1 << enc_width) + 1 && enc_width < gle_pkg::MAX_WIDTH)
					enc_width++;
				if (enc_next_code >= gle_pkg::CODE_LIMIT) begin
					pack_code(32'(gle_pkg::CODE_CLEAR));
					dict_clear();
				end
				enc_prefix = {4'd0, px};
			end
		end
		if (last) begin
			pack_code(32'(enc_prefix));
			pack_code(32'(gle_pkg::CODE_END));
			if (enc_count > 0) begin
				b.data = enc_acc[7:0];
				b.last = 1'b0;
				step_bytes = {step_bytes, b};
				enc_acc = 0;
				enc_count = 0;
			end
			step_bytes[step_bytes.size()-1].last = 1'b1;
			enc_in_image = 1'b0;
			enc_prefix = '0;
			dict_clear();
		end
	endfunction

	function automatic void add_pixel(input logic [7:0] px, input logic last);
		stim_t s;
		s.pixel = px;
		s.last = last;
		s.typed = 1'b0;
		stim = {stim, s};
	endfunction

	function automatic void add_typed(input logic [7:0] px, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
		stim_t s;
		s.pixel = px;
		s.last = 1'b1;
		s.typed = 1'b1;
		s.bytes = '{b0, b1, b2, b3};
		stim = {stim, s};
	endfunction

	function automatic void build_stimulus();
		int len;
		int alpha;
		// single-pixel images at both pixel extremes: clear, pixel, end in 27 bits
		add_typed(8'h00, 8'h00, 8'h01, 8'h04, 8'h04);
		add_typed(8'hFF, 8'h00, 8'hFF, 8'h05, 8'h04);
		// a run of one value: string hits growing
		for (int i = 0; i < 7; i++) add_pixel(8'h07, i == 6);
		// alternating values, then pixel 255 repeated
		for (int i = 0; i < 8; i++) add_pixel(i[0] ? 8'hFF : 8'h00, 1'b0);
		for (int i = 0; i < 5; i++) add_pixel(8'hFF, i == 4);
		add_pixel(8'hA5, 1'b1);
		for (int n = 0; n < 285; n += len) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			alpha = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 7);
			for (int i = 0; i < len; i++)
				add_pixel(8'($urandom_range(0, alpha)), i == len - 1);
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel = '0;
		last_pixel = 1'b0;
		out_ready = 1'b0;
		send_idx = 0;
		accept_idx = 0;
		errors = 0;
		idle_cycles = 0;
		hold_done = 1'b0;
		enc_in_image = 1'b0;
		enc_prefix = '0;
		enc_acc = 0;
		enc_count = 0;
		dict_clear();
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit no_idle_window();
		return accept_idx > 180 && accept_idx < 260;
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) send_idx++;
			if (send_idx < stim.size() && (no_idle_window() || $urandom_range(0, 99) >= 31)) begin
				in_valid <= 1'b1;
				pixel <= stim[send_idx].pixel;
				last_pixel <= stim[send_idx].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && accept_idx >= 120) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= no_idle_window() || $urandom_range(0, 99) >= 31;
		end
	end

	// checker and watchdog
	always @(posedge clk) begin
		out_byte_t e;
		if (in_valid && in_ready) begin
			lzw_encode_pixel(pixel, last_pixel);
			if (stim[accept_idx].typed) begin
				for (int i = 0; i < 4; i++) begin
					e.data = stim[accept_idx].bytes[i];
					e.last = (i == 3);
					expected_bytes = {expected_bytes, e};
				end
			end else begin
				expected_bytes = {expected_bytes, step_bytes};
			end
			accept_idx++;
		end
		if (out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", code_byte));
			end else begin
				e = expected_bytes.pop_front();
				if (code_byte !== e.data)
					report_mismatch($sformatf("code_byte %02h, want %02h", code_byte, e.data));
				if (last_byte !== e.last)
					report_mismatch($sformatf("last_byte %b, want %b", last_byte, e.last));
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d bytes outstanding", expected_bytes.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (stim.size() > 0 && accept_idx == stim.size() && expected_bytes.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
